// File: design/assert_macros.svh
// assertion helpers used by the checker of this project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/vwp_pkg.sv
package vwp_pkg;

   // fixed field widths
   localparam int K_GROUPS_W   = 13;
   localparam int BLOCKS_W     = 11;
   localparam int BLOCK_IDX_W  = 10;
   localparam int EXPERT_OUT_W = 8;
   localparam int OFFSET_W     = 18;
   localparam int WORD_W       = 32;
   localparam int CSR_DATA_W   = 13;
   localparam int MAX_BLOCKS   = 1024;
   // compensation scale is 0x80, applied as a shift
   localparam int COMP_SHIFT   = 7;
   localparam int RSP_TDATA_W  = 72;
   localparam int RSP_PAD_W    = RSP_TDATA_W - EXPERT_OUT_W - BLOCK_IDX_W - OFFSET_W - WORD_W;

   // register indexes on the csr port
   typedef enum logic [0:0] {
      CSR_K_GROUPS      = 1'b0,
      CSR_EXPERT_BLOCKS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [K_GROUPS_W-1:0] k_groups;
      logic [BLOCKS_W-1:0]   expert_blocks;
   } cfg_type;

   typedef struct packed {
      logic [EXPERT_OUT_W-1:0] expert_index;
      logic [BLOCK_IDX_W-1:0]  block_in_expert;
      logic [OFFSET_W-1:0]     word_offset;
      logic [WORD_W-1:0]       data_word;
      logic                    is_compensation;
      logic                    last;
   } result_type;

   // what one input word produces: the weight result and maybe a compensation result
   typedef struct packed {
      result_type weight;
      result_type comp;
      logic       has_comp;
   } pair_type;

endpackage

// File: design/vwp_datapath.sv
module vwp_datapath #(
   parameter int BLOCK_CHANNELS = 32,
   parameter int MAX_K_GROUPS   = 4096,
   parameter int MAX_EXPERTS    = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [vwp_pkg::WORD_W-1:0]    word,
   input  vwp_pkg::cfg_type              cfg,
   output vwp_pkg::pair_type             pair
);

   localparam int KG_W = $clog2(MAX_K_GROUPS + 1);
   localparam int GC_W = (MAX_K_GROUPS > 1) ? $clog2(MAX_K_GROUPS) : 1;
   localparam int CH_W = $clog2(BLOCK_CHANNELS);
   localparam int EX_W = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;

   logic [CH_W-1:0]                 channel_ff, channel_in;
   logic [GC_W-1:0]                 group_ff, group_in;
   logic [vwp_pkg::WORD_W-1:0]      sum_ff, sum_in;
   logic [vwp_pkg::BLOCK_IDX_W-1:0] block_ff, block_in;
   logic [EX_W-1:0]                 expert_ff, expert_in;

   logic [KG_W-1:0]                 eff_kg;
   logic [vwp_pkg::BLOCKS_W-1:0]    eff_blocks;
   logic [KG_W-1:0]                 group_next;
   logic [vwp_pkg::BLOCKS_W-1:0]    block_next;
   logic                            chan_end;
   logic                            chan_last;
   logic                            block_end;
   logic [vwp_pkg::WORD_W-1:0]      scaled [4];
   logic [vwp_pkg::WORD_W-1:0]      new_sum;

   // effective limits: zero acts as one, oversize clamps
   always_comb begin
      if (cfg.k_groups == '0) begin
         eff_kg = KG_W'(1);
      end else if (32'(cfg.k_groups) > 32'(MAX_K_GROUPS)) begin
         eff_kg = KG_W'(MAX_K_GROUPS);
      end else begin
         eff_kg = KG_W'(cfg.k_groups);
      end
      if (cfg.expert_blocks == '0) begin
         eff_blocks = vwp_pkg::BLOCKS_W'(1);
      end else if (cfg.expert_blocks > vwp_pkg::BLOCKS_W'(vwp_pkg::MAX_BLOCKS)) begin
         eff_blocks = vwp_pkg::BLOCKS_W'(vwp_pkg::MAX_BLOCKS);
      end else begin
         eff_blocks = cfg.expert_blocks;
      end
   end

   // end-of-level tests
   assign group_next = KG_W'(group_ff) + KG_W'(1);
   assign chan_end   = group_next >= eff_kg;
   assign chan_last  = channel_ff == CH_W'(BLOCK_CHANNELS - 1);
   assign block_next = vwp_pkg::BLOCKS_W'(block_ff) + vwp_pkg::BLOCKS_W'(1);
   assign block_end  = block_next >= eff_blocks;

   // four sign-extended bytes times 0x80, added to the running sum
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         scaled[i] = {{(vwp_pkg::WORD_W - 8 - vwp_pkg::COMP_SHIFT){word[8*i+7]}},
                      word[8*i +: 8], {vwp_pkg::COMP_SHIFT{1'b0}}};
      end
      new_sum = sum_ff + scaled[0] + scaled[1] + scaled[2] + scaled[3];
   end

   // result pair
   always_comb begin
      pair.weight.expert_index    = vwp_pkg::EXPERT_OUT_W'(expert_ff);
      pair.weight.block_in_expert = block_ff;
      pair.weight.word_offset     = vwp_pkg::OFFSET_W'(group_ff)
                                    * vwp_pkg::OFFSET_W'(BLOCK_CHANNELS)
                                    + vwp_pkg::OFFSET_W'(channel_ff);
      pair.weight.data_word       = word;
      pair.weight.is_compensation = 1'b0;
      pair.weight.last            = !chan_end;

      pair.comp.expert_index      = vwp_pkg::EXPERT_OUT_W'(expert_ff);
      pair.comp.block_in_expert   = block_ff;
      pair.comp.word_offset       = vwp_pkg::OFFSET_W'(eff_kg)
                                    * vwp_pkg::OFFSET_W'(BLOCK_CHANNELS)
                                    + vwp_pkg::OFFSET_W'(channel_ff);
      pair.comp.data_word         = new_sum;
      pair.comp.is_compensation   = 1'b1;
      pair.comp.last              = 1'b1;

      pair.has_comp               = chan_end;
   end

   // counter next values
   always_comb begin
      channel_in = channel_ff;
      group_in   = group_ff;
      sum_in     = sum_ff;
      block_in   = block_ff;
      expert_in  = expert_ff;
      if (push) begin
         if (!chan_end) begin
            sum_in   = new_sum;
            group_in = GC_W'(group_next);
         end else begin
            sum_in   = '0;
            group_in = '0;
            if (chan_last) begin
               channel_in = '0;
               if (block_end) begin
                  block_in = '0;
                  if (expert_ff == EX_W'(MAX_EXPERTS - 1)) begin
                     expert_in = '0;
                  end else begin
                     expert_in = expert_ff + EX_W'(1);
                  end
               end else begin
                  block_in = vwp_pkg::BLOCK_IDX_W'(block_next);
               end
            end else begin
               channel_in = channel_ff + CH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= '0;
         group_ff   <= '0;
         sum_ff     <= '0;
         block_ff   <= '0;
         expert_ff  <= '0;
      end else begin
         channel_ff <= channel_in;
         group_ff   <= group_in;
         sum_ff     <= sum_in;
         block_ff   <= block_in;
         expert_ff  <= expert_in;
      end
   end

endmodule

// File: design/vwp_rsp_buf.sv
module vwp_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  vwp_pkg::pair_type    pair,
   output logic                 load_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output vwp_pkg::result_type  head
);

   // holds the weight result and, behind it, the compensation result
   vwp_pkg::result_type slot0_ff, slot0_in;
   vwp_pkg::result_type slot1_ff, slot1_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;

   assign rsp_valid  = count_ff != 2'd0;
   assign pop        = rsp_valid && rsp_ready;
   assign load_ready = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);
   assign head       = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (push) begin
         slot0_in = pair.weight;
         slot1_in = pair.comp;
         count_in = pair.has_comp ? 2'd2 : 2'd1;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// File: design/vnni_weight_pack_with_compensation.sv
// Packs int8 weight words for VNNI dot products and appends per-channel
// zero-point compensation. Each 32-bit word on req is four signed weights of one
// channel; words arrive expert, block, channel, k-group order. Every word comes
// back on rsp with its packed word offset (k-group * BLOCK_CHANNELS + channel);
// after a channel's last k-group a second word follows carrying 128 times the
// channel's weight sum (wrapping at 32 bits) at offset k_groups * BLOCK_CHANNELS
// + channel, flagged by rsp_tuser. rsp_tlast marks the final word produced by an
// input word. An input word is taken every cycle while rsp keeps up; a word that
// ends a channel produces two rsp words, which leave one after the other through the
// single rsp port of the two-slot result buffer. Each word passes through the input
// register and then the result register. Write csr registers (0: k_groups,
// 1: expert_blocks) only while the block is idle; both reset to 1.
module vnni_weight_pack_with_compensation #(
   parameter int BLOCK_CHANNELS = 32,
   parameter int MAX_K_GROUPS   = 4096,
   parameter int MAX_EXPERTS    = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   // req: weight_word [31:0]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vwp_pkg::WORD_W-1:0]         req_tdata,
   // rsp: expert_index [7:0], block_in_expert [17:8], word_offset [35:18],
   // data_word [67:36], zero [71:68]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vwp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: is_compensation [0]
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [0:0]                         csr_index,
   input  logic [vwp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                       in_valid_ff, in_valid_in;
   logic [vwp_pkg::WORD_W-1:0] in_word_ff, in_word_in;
   vwp_pkg::cfg_type           cfg_ff, cfg_in;
   vwp_pkg::pair_type          pair;
   vwp_pkg::result_type        head;
   logic                       load_ready;
   logic                       push;
   logic                       req_take;

   // config registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (vwp_pkg::csr_index_type'(csr_index))
            vwp_pkg::CSR_K_GROUPS: begin
               cfg_in.k_groups = csr_wdata[vwp_pkg::K_GROUPS_W-1:0];
            end
            vwp_pkg::CSR_EXPERT_BLOCKS: begin
               cfg_in.expert_blocks = csr_wdata[vwp_pkg::BLOCKS_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.k_groups      <= vwp_pkg::K_GROUPS_W'(1);
         cfg_ff.expert_blocks <= vwp_pkg::BLOCKS_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   assign push       = in_valid_ff && load_ready;
   assign req_tready = !in_valid_ff || push;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_tdata;
      end else if (push) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   // offsets, sums and counters
   vwp_datapath #(
      .BLOCK_CHANNELS (BLOCK_CHANNELS),
      .MAX_K_GROUPS   (MAX_K_GROUPS),
      .MAX_EXPERTS    (MAX_EXPERTS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .word  (in_word_ff),
      .cfg   (cfg_ff),
      .pair  (pair)
   );

   // result register
   vwp_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pair       (pair),
      .load_ready (load_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .head       (head)
   );

   // rsp word packing
   assign rsp_tdata = {{vwp_pkg::RSP_PAD_W{1'b0}}, head.data_word, head.word_offset,
                       head.block_in_expert, head.expert_index};
   assign rsp_tuser = head.is_compensation;
   assign rsp_tlast = head.last;

endmodule

// File: design/vwp_checker.sv
`include "assert_macros.svh"

module vwp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [vwp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);

   // a stalled word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")

   // a compensation word always closes its input's results
   `ASSERT_SAME(a_comp_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "compensation word without tlast")

   // a weight word that closes its input's results is not followed by a compensation word
   `ASSERT_NEXT(a_comp_follows, clock, reset, rsp_tvalid && rsp_tready && !rsp_tuser && rsp_tlast, !(rsp_tvalid && rsp_tuser), "compensation word without channel end")

   // a weight word that ends a channel is followed at once by its compensation
   `ASSERT_NEXT(a_comp_ready, clock, reset, rsp_tvalid && rsp_tready && !rsp_tuser && !rsp_tlast, rsp_tvalid && rsp_tuser, "channel end not followed by compensation word")

endmodule

bind vnni_weight_pack_with_compensation vwp_checker u_vwp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
